/* src/fwpr_pkg.sv */
// ----------------------------------------------------------------------------
// fwpr_pkg: shared constants for the firmware-parameters response parser
// Header and entry layout positions, status codes and register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package fwpr_pkg;

    // Header layout (byte positions inside the 11-byte header)
    localparam logic [3:0] HDR_CC_POS     = 4'd0;
    localparam logic [3:0] HDR_COUNT_LO   = 4'd5;
    localparam logic [3:0] HDR_COUNT_HI   = 4'd6;
    localparam logic [3:0] HDR_LEN_A_POS  = 4'd8;
    localparam logic [3:0] HDR_LEN_B_POS  = 4'd10;
    localparam logic [3:0] HDR_LAST_POS   = 4'd10;

    // Component entry layout
    localparam logic [9:0] ENT_CLASS_LO   = 10'd0;
    localparam logic [9:0] ENT_CLASS_HI   = 10'd1;
    localparam logic [9:0] ENT_ACTIVE_LEN = 10'd10;
    localparam logic [9:0] ENT_PEND_LEN   = 10'd24;
    localparam logic [9:0] ENT_FIXED      = 10'd39;

    // Status codes
    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_TOO_SHORT     = 3'd1,
        ST_BAD_COMPLETE  = 3'd2,
        ST_NO_COMPONENTS = 3'd3,
        ST_TRUNCATED     = 3'd4,
        ST_NOT_FOUND     = 3'd5
    } status_t;

    localparam logic [15:0] TARGET_CLASS_RESET = 16'd10;

endpackage

`default_nettype wire

/* src/fw_param_response_version_parser.sv */
// ----------------------------------------------------------------------------
// fw_param_response_version_parser
// Parses a firmware-parameters response byte stream and passes out the
// active version string of the first component of the selected class whose string is not empty.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                   | payload
//  ---------+-----+-----------------------------+--------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready | tdata: data_byte, tlast: last
//  m_axis   | out | m_axis_tvalid/m_axis_tready | tdata: version_char, status
//           |     |                             | tuser: char_valid, done_res
//  cfg      | in  | cfg_valid/cfg_ready         | cfg_data: target_class
//
// One byte per cycle: each request is parsed in the cycle it is accepted and
// its result, if any, lands in the output register on the next edge.
// Throughput is set by the single output register: a request is taken while
// the register is empty or being drained by the sink.
// Reset returns the parser to the header phase and target_class to 10.
// The parser state also returns to the header phase after every last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module fw_param_response_version_parser
    import fwpr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // last

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] version_char, [10:8] status, rest 0
    output logic [1:0]       m_axis_tuser,   // [0] char_valid, [1] done_res

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data        // target_class
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SKIP,
        PH_ENTRY,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  header_index_reg, header_index_next;
    logic        completion_bad_reg, completion_bad_next;
    logic [15:0] components_left_reg, components_left_next;
    logic [8:0]  skip_left_reg, skip_left_next;
    logic [9:0]  entry_position_reg, entry_position_next;
    logic [7:0]  active_length_reg, active_length_next;
    logic [7:0]  pending_length_reg, pending_length_next;
    logic [7:0]  class_low_byte_reg, class_low_byte_next;
    logic        entry_matches_reg, entry_matches_next;
    logic [15:0] target_class_reg;

    logic        out_valid_reg;
    logic [7:0]  out_char_reg;
    status_t     out_status_reg;
    logic        out_cv_reg;
    logic        out_done_reg;

    logic        s_fire;
    logic        have;
    logic        cv;
    logic        done;
    status_t     st;
    logic [9:0]  end_pos;
    logic [9:0]  active_end;
    logic [7:0]  active_eff;
    logic [7:0]  pending_eff;
    logic [8:0]  skip_dec;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign active_eff  = (entry_position_reg == ENT_ACTIVE_LEN) ? s_axis_tdata
                                                                : active_length_reg;
    assign pending_eff = (entry_position_reg == ENT_PEND_LEN) ? s_axis_tdata
                                                              : pending_length_reg;
    assign active_end  = ENT_FIXED + {2'd0, active_eff};
    assign end_pos     = ENT_FIXED - 10'd1 + {2'd0, active_eff} + {2'd0, pending_eff};
    assign skip_dec    = skip_left_reg - 9'd1;

    always_comb
    begin
        phase_next           = phase_reg;
        header_index_next    = header_index_reg;
        completion_bad_next  = completion_bad_reg;
        components_left_next = components_left_reg;
        skip_left_next       = skip_left_reg;
        entry_position_next  = entry_position_reg;
        active_length_next   = active_length_reg;
        pending_length_next  = pending_length_reg;
        class_low_byte_next  = class_low_byte_reg;
        entry_matches_next   = entry_matches_reg;
        have = 1'b0;
        cv   = 1'b0;
        done = 1'b0;
        st   = ST_OK;

        case (phase_reg)
            PH_HEADER:
            begin
                if (header_index_reg == HDR_CC_POS)
                    completion_bad_next = (s_axis_tdata != 8'd0);
                else if (header_index_reg == HDR_COUNT_LO)
                    components_left_next = {8'd0, s_axis_tdata};
                else if (header_index_reg == HDR_COUNT_HI)
                    components_left_next = {s_axis_tdata, components_left_reg[7:0]};
                else if (header_index_reg == HDR_LEN_A_POS)
                    skip_left_next = {1'b0, s_axis_tdata};
                else if (header_index_reg == HDR_LEN_B_POS)
                    skip_left_next = skip_left_reg + {1'b0, s_axis_tdata};

                if (header_index_reg >= HDR_LAST_POS)
                begin
                    if (completion_bad_reg)
                    begin
                        done = 1'b1;
                        st   = ST_BAD_COMPLETE;
                    end
                    else if (components_left_next == 16'd0)
                    begin
                        done = 1'b1;
                        st   = ST_NO_COMPONENTS;
                    end
                    else
                    begin
                        phase_next          = (skip_left_next != 9'd0) ? PH_SKIP : PH_ENTRY;
                        entry_position_next = '0;
                        entry_matches_next  = 1'b0;
                    end
                end
                else
                begin
                    header_index_next = header_index_reg + 4'd1;
                end
            end
            PH_SKIP:
            begin
                skip_left_next = skip_dec;
                if (skip_dec == 9'd0)
                begin
                    phase_next          = PH_ENTRY;
                    entry_position_next = '0;
                    entry_matches_next  = 1'b0;
                end
            end
            PH_ENTRY:
            begin
                if (entry_position_reg == ENT_CLASS_LO)
                    class_low_byte_next = s_axis_tdata;
                else if (entry_position_reg == ENT_CLASS_HI)
                    entry_matches_next = ({s_axis_tdata, class_low_byte_reg} == target_class_reg);
                else if (entry_position_reg == ENT_ACTIVE_LEN)
                    active_length_next = s_axis_tdata;
                else if (entry_position_reg == ENT_PEND_LEN)
                    pending_length_next = s_axis_tdata;

                // pass active string characters of the matching entry
                if (entry_matches_reg && entry_position_reg >= ENT_FIXED
                    && entry_position_reg < active_end)
                begin
                    cv   = 1'b1;
                    have = 1'b1;
                end

                if (entry_position_reg == end_pos)
                begin
                    if (entry_matches_reg && active_eff != 8'd0)
                    begin
                        done = 1'b1;
                        st   = ST_OK;
                    end
                    else
                    begin
                        components_left_next = components_left_reg - 16'd1;
                        if (components_left_next == 16'd0)
                        begin
                            done = 1'b1;
                            st   = ST_NOT_FOUND;
                        end
                        else
                        begin
                            entry_position_next = '0;
                            entry_matches_next  = 1'b0;
                        end
                    end
                end
                else
                begin
                    entry_position_next = entry_position_reg + 10'd1;
                end
            end
            default:
            begin
                // status already given: drop bytes until the last mark
            end
        endcase

        if (done)
        begin
            phase_next = PH_DONE;
            have       = 1'b1;
        end

        if (s_axis_tlast)
        begin
            if (phase_next != PH_DONE)
            begin
                done = 1'b1;
                st   = (phase_next == PH_HEADER) ? ST_TOO_SHORT : ST_TRUNCATED;
                have = 1'b1;
            end
            phase_next           = PH_HEADER;
            header_index_next    = '0;
            completion_bad_next  = 1'b0;
            components_left_next = '0;
            skip_left_next       = '0;
            entry_position_next  = '0;
            active_length_next   = '0;
            pending_length_next  = '0;
            class_low_byte_next  = '0;
            entry_matches_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_HEADER;
            header_index_reg    <= '0;
            completion_bad_reg  <= 1'b0;
            components_left_reg <= '0;
            skip_left_reg       <= '0;
            entry_position_reg  <= '0;
            active_length_reg   <= '0;
            pending_length_reg  <= '0;
            class_low_byte_reg  <= '0;
            entry_matches_reg   <= 1'b0;
            target_class_reg    <= TARGET_CLASS_RESET;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                target_class_reg <= cfg_data;

            if (s_fire)
            begin
                phase_reg           <= phase_next;
                header_index_reg    <= header_index_next;
                completion_bad_reg  <= completion_bad_next;
                components_left_reg <= components_left_next;
                skip_left_reg       <= skip_left_next;
                entry_position_reg  <= entry_position_next;
                active_length_reg   <= active_length_next;
                pending_length_reg  <= pending_length_next;
                class_low_byte_reg  <= class_low_byte_next;
                entry_matches_reg   <= entry_matches_next;
            end

            if (s_fire && have)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload: loaded only with a request that produces a result
    always_ff @(posedge clk)
    begin
        if (s_fire && have)
        begin
            out_cv_reg     <= cv;
            out_char_reg   <= cv ? s_axis_tdata : 8'd0;
            out_done_reg   <= done;
            out_status_reg <= done ? st : ST_OK;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_status_reg, out_char_reg};
    assign m_axis_tuser  = {out_done_reg, out_cv_reg};

    // a result always carries a character, a status or both
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] || m_axis_tuser[1]))
        else $error("result with neither character nor status");

    // status field is zero unless the status is final
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[1]) |-> (m_axis_tdata[10:8] == 3'd0))
        else $error("status set without done");

    // a last byte always returns the parser to the start of a header
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_axis_tlast) |=> (phase_reg == PH_HEADER && header_index_reg == 4'd0))
        else $error("parser not cleared after last byte");

    // after a status, bytes without a last mark give no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && phase_reg == PH_DONE && !s_axis_tlast && m_axis_tready)
        |=> !m_axis_tvalid)
        else $error("result produced after status was given");

endmodule

`default_nettype wire
